>>> design/ppp_pkg.sv
package ppp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SIZE_W    = 14;
  localparam int OFF_W     = 8;
  localparam int PRD_W     = 64 - FRAC_BITS;
  localparam int CLIP_W    = PRD_W + 2;
  localparam int NUM_W     = CLIP_W + 1;
  localparam int DEN_W     = CLIP_W + 1;
  localparam int DVD_W     = NUM_W + SIZE_W + FRAC_BITS;
  localparam int QBITS     = 31;
  localparam longint NEAR_Q = ((64'sd1 <<< FRAC_BITS) + 5) / 10;

  localparam logic       OP_LOAD    = 1'b0;
  localparam logic       OP_PROJECT = 1'b1;

  localparam logic [1:0] REG_VP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_VP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_Y_OFFSET  = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               visible;
  } out_item_t;

endpackage

>>> design/ppp_mat_ram.sv
module ppp_mat_ram
  import ppp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [16];
  logic [15:0] vld_r;
  logic [31:0] dat_r;
  logic        hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    dat_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      hit_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = hit_r ? dat_r : '0;

endmodule

>>> design/ppp_div.sv
module ppp_div
  import ppp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  num,
  input  logic signed [CLIP_W-1:0] den,
  input  logic [SIZE_W-1:0]        size,
  output logic                     done,
  output logic signed [31:0]       quot
);

  localparam int CMP_W = DVD_W + DEN_W + QBITS;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_CHK  = 4'b0010,
    D_ITER = 4'b0100,
    D_DONE = 4'b1000
  } dstate_t;

  dstate_t              st_r;
  logic [DVD_W-1:0]     dvd_r;
  logic [DEN_W-1:0]     d_r;
  logic [DEN_W-1:0]     rem_r;
  logic [QBITS-1:0]     low_r;
  logic [QBITS-1:0]     q_r;
  logic [4:0]           cnt_r;
  logic                 neg_r;
  logic                 ovf_r;

  logic [NUM_W-1:0]        mag_num;
  logic [CLIP_W-1:0]       mag_den;
  logic [NUM_W+SIZE_W-1:0] pm;
  logic [DEN_W:0]          r2;
  logic                    ge;
  logic                    ovf;

  assign mag_num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign mag_den = den[CLIP_W-1] ? CLIP_W'(-den) : CLIP_W'(den);
  assign pm      = (NUM_W+SIZE_W)'(mag_num) * (NUM_W+SIZE_W)'(size);
  assign ovf     = CMP_W'(dvd_r) >= (CMP_W'(d_r) << QBITS);
  assign r2      = {rem_r, low_r[QBITS-1]};
  assign ge      = r2 >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
    end else if (start) begin
      st_r  <= D_CHK;
      neg_r <= num[NUM_W-1] ^ den[CLIP_W-1];
      dvd_r <= {pm, {FRAC_BITS{1'b0}}};
      d_r   <= {mag_den, 1'b0};
    end else begin
      unique case (st_r)
        D_IDLE: ;
        D_CHK: begin
          ovf_r <= ovf;
          rem_r <= DEN_W'(dvd_r >> QBITS);
          low_r <= dvd_r[QBITS-1:0];
          q_r   <= '0;
          cnt_r <= 5'(QBITS - 1);
          st_r  <= ovf ? D_DONE : D_ITER;
        end
        D_ITER: begin
          rem_r <= ge ? DEN_W'(r2 - {1'b0, d_r}) : DEN_W'(r2);
          low_r <= {low_r[QBITS-2:0], 1'b0};
          q_r   <= {q_r[QBITS-2:0], ge};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            st_r <= D_DONE;
          end
        end
        D_DONE: st_r <= D_IDLE;
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign done = (st_r == D_DONE);

  always_comb begin
    priority if (ovf_r) begin
      quot = neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg_r) begin
      quot = -$signed({1'b0, q_r});
    end else begin
      quot = $signed({1'b0, q_r});
    end
  end

endmodule

>>> design/perspective_point_projection.sv
// Load item: matrix entry written at the transfer edge.
// Project item: sixteen matrix reads, twelve products through one 32x32 multiplier
// plus four entries added as they are, then the near check, then (for a visible point)
// two divisions by w (31 steps each) on one shared divider, and the result is registered.
// One item is in work at a time; the next is taken only once the result has moved to the output register.
// Reset (rst_n low, synchronous): matrix reads as zero, viewport 640x480,
// screen y offset 5, no result pending.
module perspective_point_projection
  import ppp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAC  = 5'b00010,
    S_CHK  = 5'b00100,
    S_DIVX = 5'b01000,
    S_DIVY = 5'b10000
  } state_t;

  state_t                   state_r;
  logic [SIZE_W-1:0]        vp_w_r, vp_h_r;
  logic signed [OFF_W-1:0]  y_off_r;
  logic signed [31:0]       px_r, py_r, pz_r;
  logic [4:0]               cnt_r;
  logic                     s1_v_r;
  logic [3:0]               s1_idx_r;
  logic                     prod_v_r;
  logic [1:0]               prod_row_r;
  logic signed [PRD_W-1:0]  prod_r;
  logic signed [CLIP_W-1:0] acc_r [4];
  logic                     out_valid_r;
  out_item_t                out_r;
  logic signed [31:0]       sx_r;
  logic                     pend_r;
  out_item_t                pend_item_r;

  logic                     in_xfer, out_xfer;
  logic [31:0]              rd_data;
  logic signed [31:0]       coord;
  logic signed [63:0]       mult;
  logic signed [PRD_W-1:0]  prod_nxt;
  logic                     invis;
  logic                     div_start, div_done;
  logic signed [NUM_W-1:0]  div_num;
  logic [SIZE_W-1:0]        div_size;
  logic signed [31:0]       quot;
  logic signed [33:0]       y_sum;
  logic signed [31:0]       y_sat;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE) || pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_w_r  <= SIZE_W'(640);
      vp_h_r  <= SIZE_W'(480);
      y_off_r <= OFF_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VP_WIDTH:  vp_w_r  <= cfg_data;
        REG_VP_HEIGHT: vp_h_r  <= cfg_data;
        REG_Y_OFFSET:  y_off_r <= cfg_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  ppp_mat_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_xfer && in_data.opcode == OP_LOAD),
    .wr_addr (in_data.entry_index),
    .wr_data (in_data.entry_value),
    .rd_addr (cnt_r[3:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    unique case (s1_idx_r[3:2])
      2'd0:    coord = px_r;
      2'd1:    coord = py_r;
      default: coord = pz_r;
    endcase
  end

  assign mult = coord * $signed(rd_data);
  assign prod_nxt = (s1_idx_r[3:2] == 2'd3) ?
                    PRD_W'($signed(rd_data)) : mult[63:FRAC_BITS];

  assign invis = (64'(acc_r[2]) < NEAR_Q) || (acc_r[3] == '0);

  assign div_start = (state_r == S_CHK && !invis) || (state_r == S_DIVX && div_done);
  assign div_num   = (state_r == S_CHK) ? (NUM_W'(acc_r[3]) + NUM_W'(acc_r[0])) :
                                          (NUM_W'(acc_r[3]) - NUM_W'(acc_r[1]));
  assign div_size  = (state_r == S_CHK) ? vp_w_r : vp_h_r;

  ppp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (acc_r[3]),
    .size  (div_size),
    .done  (div_done),
    .quot  (quot)
  );

  assign y_sum = 34'(quot) + (34'(y_off_r) <<< FRAC_BITS);
  always_comb begin
    priority if (y_sum > 34'sh0_7FFF_FFFF) begin
      y_sat = 32'sh7FFF_FFFF;
    end else if (y_sum < -34'sh0_8000_0000) begin
      y_sat = 32'sh8000_0000;
    end else begin
      y_sat = y_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      s1_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      s1_v_r     <= (state_r == S_MAC) && !cnt_r[4];
      s1_idx_r   <= cnt_r[3:0];
      prod_v_r   <= s1_v_r;
      prod_r     <= prod_nxt;
      prod_row_r <= s1_idx_r[1:0];
      if (prod_v_r) begin
        for (int i = 0; i < 4; i++) begin
          if (prod_row_r == 2'(i)) begin
            acc_r[i] <= acc_r[i] + CLIP_W'(prod_r);
          end
        end
      end

      if (pend_r && (!out_valid_r || out_xfer)) begin
        out_r       <= pend_item_r;
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && in_data.opcode == OP_PROJECT) begin
            px_r    <= in_data.point_x;
            py_r    <= in_data.point_y;
            pz_r    <= in_data.point_z;
            cnt_r   <= '0;
            for (int i = 0; i < 4; i++) begin
              acc_r[i] <= '0;
            end
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd17) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (invis) begin
            pend_item_r <= '{screen_x: '0, screen_y: '0, visible: 1'b0};
            pend_r      <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            sx_r    <= quot;
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            pend_item_r <= '{screen_x: sx_r, screen_y: y_sat, visible: 1'b1};
            pend_r      <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");

  a_div_done_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVX || state_r == S_DIVY))
    else $error("divider finished outside a division state");

  a_invis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.visible |-> out_r.screen_x == '0 && out_r.screen_y == '0)
    else $error("invisible result carries coordinates");

  a_pend_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> in_stall) else $error("input taken with result pending");

endmodule
